// ===== rtl/aip_pkg.sv =====
// Shared types and character constants for the ASCII integer parser.
`default_nettype none
package aip_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Classified character as it travels from front to back.
  typedef struct packed {
    logic              first;
    logic              blank;
    logic              minus;
    logic              zero;
    logic              xchar;
    logic              digit;
    logic              hexdig;
    logic              hex_end;
    logic              dec_end;
    logic [NIB_W-1:0]  nib;
  } cls_t;

  localparam int unsigned CLS_W = $bits(cls_t);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_NEG_WS,
    PH_NEG_DIG,
    PH_NEG_TAIL,
    PH_ZERO,
    PH_HEX,
    PH_DEC
  } phase_t;

endpackage
`default_nettype wire

// ===== rtl/aip_front.sv =====
// Front end: input handshake and character classification.
`default_nettype none
module aip_front (
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,
  input  wire logic [0:0]       in_tuser,
  input  wire logic             q_full,
  output logic                  q_push,
  output aip_pkg::cls_t         q_wdata
);

  logic [7:0] c;
  logic       is_dig;
  logic       is_lc;
  logic       is_uc;
  logic       is_blank;
  logic       is_hex_end;

  assign c          = in_tdata;
  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && !q_full;

  assign is_dig     = (c >= aip_pkg::CH_0) && (c <= aip_pkg::CH_9);
  assign is_lc      = (c >= aip_pkg::CH_LA) && (c <= aip_pkg::CH_LF);
  assign is_uc      = (c >= aip_pkg::CH_UA) && (c <= aip_pkg::CH_UF);
  assign is_blank   = (c == aip_pkg::CH_SPACE) || (c == aip_pkg::CH_TAB);
  assign is_hex_end = (c == aip_pkg::CH_NUL) || (c == aip_pkg::CH_RPAR) || is_blank;

  always_comb begin
    q_wdata.first   = in_tuser[0];
    q_wdata.blank   = is_blank;
    q_wdata.minus   = (c == aip_pkg::CH_MINUS);
    q_wdata.zero    = (c == aip_pkg::CH_0);
    q_wdata.xchar   = (c == aip_pkg::CH_LX) || (c == aip_pkg::CH_UX);
    q_wdata.digit   = is_dig;
    q_wdata.hexdig  = is_dig || is_lc || is_uc;
    q_wdata.hex_end = is_hex_end;
    q_wdata.dec_end = is_hex_end || (c == aip_pkg::CH_PLUS) || (c == aip_pkg::CH_MINUS)
                      || (c == aip_pkg::CH_STAR) || (c == aip_pkg::CH_SLASH)
                      || (c == aip_pkg::CH_SEMI) || (c == aip_pkg::CH_COLON);
    // Letters a-f and A-F map to 10-15 through their low bits plus nine.
    if (is_dig) begin
      q_wdata.nib = c[3:0];
    end else begin
      q_wdata.nib = c[3:0] + 4'd9;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aip_queue.sv =====
// Two-entry register queue between the front and back ends.
`default_nettype none
module aip_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0]            mem_r [aip_pkg::QDEPTH];
  logic [aip_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [aip_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [aip_pkg::QCNT_W-1:0]  cnt_r;
  logic [aip_pkg::QCNT_W-1:0]  cnt_nxt;
  logic                        do_pop;

  assign full   = (cnt_r == aip_pkg::QCNT_W'(aip_pkg::QDEPTH));
  assign valid  = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aip_back.sv =====
// Back end: parse state machine, accumulator and output register.
`default_nettype none
module aip_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire aip_pkg::cls_t                 q_rdata,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [aip_pkg::VALUE_W-1:0]        out_tdata,
  output logic [0:0]                         out_tuser
);

  aip_pkg::phase_t               phase_r;
  aip_pkg::phase_t               phase_nxt;
  aip_pkg::phase_t               ph_eff;
  logic [aip_pkg::VALUE_W-1:0]   accum_r;
  logic [aip_pkg::VALUE_W-1:0]   accum_nxt;
  logic [aip_pkg::VALUE_W-1:0]   acc_eff;
  logic [aip_pkg::VALUE_W-1:0]   acc_dec;
  logic [aip_pkg::VALUE_W-1:0]   acc_hex;
  logic [aip_pkg::VALUE_W-1:0]   acc_neg;
  logic [aip_pkg::VALUE_W-1:0]   acc_sgn;
  logic [aip_pkg::VALUE_W-1:0]   nib_ext;
  logic                          neg_r;
  logic                          neg_nxt;
  logic                          neg_eff;
  logic                          emit;
  logic [aip_pkg::VALUE_W-1:0]   emit_value;
  logic                          emit_error;
  logic                          out_valid_r;
  logic [aip_pkg::VALUE_W-1:0]   out_value_r;
  logic                          out_error_r;
  aip_pkg::cls_t                 c;

  assign c     = q_rdata;
  assign q_pop = q_valid && (!out_valid_r || out_tready);

  // A first-marked item restarts the parse before it is looked at.
  assign ph_eff  = c.first ? aip_pkg::PH_LEAD : phase_r;
  assign acc_eff = c.first ? '0 : accum_r;
  assign neg_eff = c.first ? 1'b0 : neg_r;

  assign nib_ext = {{(aip_pkg::VALUE_W-aip_pkg::NIB_W){1'b0}}, c.nib};
  assign acc_dec = (acc_eff << 3) + (acc_eff << 1) + nib_ext;
  assign acc_hex = {acc_eff[aip_pkg::VALUE_W-aip_pkg::NIB_W-1:0], c.nib};
  assign acc_neg = '0 - acc_eff;
  assign acc_sgn = neg_eff ? acc_neg : acc_eff;

  // Next state.
  always_comb begin
    phase_nxt = ph_eff;
    accum_nxt = acc_eff;
    neg_nxt   = neg_eff;
    unique case (ph_eff)
      aip_pkg::PH_IDLE: begin
        phase_nxt = aip_pkg::PH_IDLE;
      end
      aip_pkg::PH_LEAD: begin
        if (c.blank) begin
          phase_nxt = aip_pkg::PH_LEAD;
        end else if (c.minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = aip_pkg::PH_NEG_WS;
        end else if (c.zero) begin
          phase_nxt = aip_pkg::PH_ZERO;
        end else if (c.digit) begin
          accum_nxt = nib_ext;
          phase_nxt = aip_pkg::PH_DEC;
        end else begin
          phase_nxt = aip_pkg::PH_IDLE;
        end
      end
      aip_pkg::PH_NEG_WS, aip_pkg::PH_NEG_DIG: begin
        if (c.blank && ph_eff == aip_pkg::PH_NEG_WS) begin
          phase_nxt = aip_pkg::PH_NEG_WS;
        end else if (c.digit) begin
          accum_nxt = acc_dec;
          phase_nxt = aip_pkg::PH_NEG_DIG;
        end else if (c.blank) begin
          phase_nxt = aip_pkg::PH_NEG_TAIL;
        end else begin
          phase_nxt = aip_pkg::PH_IDLE;
        end
      end
      aip_pkg::PH_NEG_TAIL: begin
        phase_nxt = c.blank ? aip_pkg::PH_NEG_TAIL : aip_pkg::PH_IDLE;
      end
      aip_pkg::PH_ZERO: begin
        if (c.xchar) begin
          accum_nxt = '0;
          phase_nxt = aip_pkg::PH_HEX;
        end else if (c.hex_end) begin
          phase_nxt = aip_pkg::PH_IDLE;
        end else if (c.digit) begin
          accum_nxt = nib_ext;
          phase_nxt = aip_pkg::PH_DEC;
        end else begin
          phase_nxt = aip_pkg::PH_IDLE;
        end
      end
      aip_pkg::PH_HEX: begin
        if (c.hex_end || !c.hexdig) begin
          phase_nxt = aip_pkg::PH_IDLE;
        end else begin
          accum_nxt = acc_hex;
        end
      end
      aip_pkg::PH_DEC: begin
        if (c.digit) begin
          accum_nxt = acc_dec;
        end else begin
          phase_nxt = aip_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = aip_pkg::PH_IDLE;
      end
    endcase
  end

  // Result decision.
  always_comb begin
    emit       = 1'b0;
    emit_value = '0;
    emit_error = 1'b0;
    unique case (ph_eff)
      aip_pkg::PH_IDLE: begin
        emit = 1'b0;
      end
      aip_pkg::PH_LEAD: begin
        if (!(c.blank || c.minus || c.digit)) begin
          emit       = 1'b1;
          emit_error = 1'b1;
        end
      end
      aip_pkg::PH_NEG_WS, aip_pkg::PH_NEG_DIG, aip_pkg::PH_NEG_TAIL: begin
        if (!c.blank && !(c.digit && ph_eff != aip_pkg::PH_NEG_TAIL)) begin
          emit       = 1'b1;
          emit_value = acc_sgn;
          emit_error = !c.dec_end;
        end
      end
      aip_pkg::PH_ZERO: begin
        if (!c.xchar && !c.digit) begin
          emit       = 1'b1;
          emit_error = !c.hex_end;
        end
      end
      aip_pkg::PH_HEX: begin
        if (c.hex_end) begin
          emit       = 1'b1;
          emit_value = acc_eff;
        end else if (!c.hexdig) begin
          emit       = 1'b1;
          emit_error = 1'b1;
        end
      end
      aip_pkg::PH_DEC: begin
        if (!c.digit) begin
          emit       = 1'b1;
          emit_value = acc_eff;
          emit_error = !c.dec_end;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= aip_pkg::PH_IDLE;
      neg_r       <= 1'b0;
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        accum_r <= accum_nxt;
        neg_r   <= neg_nxt;
      end
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_value_r <= emit_value;
      out_error_r <= emit_error;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_error_r;

endmodule
`default_nettype wire

// ===== rtl/ascii_integer_parser.sv =====
// Top level of the streaming ASCII integer parser.
// Usage:
//   The input stream carries one character per item on in_tdata, with
//   in_tuser[0] set on the first character of each string. A first-marked
//   item always restarts the parse and drops any unfinished string.
//   The output stream carries one item per string, on the character that
//   decides it: the 64-bit value on out_tdata and the error flag on
//   out_tuser[0]. Characters after the decision give nothing until the
//   next first-marked item.
//   Throughput is one character per cycle unless the output stalls. The
//   character is classified and written into the two-entry queue at the
//   accepting edge; the parse state machine then pops it and loads the
//   output register, which raises out_tvalid for the deciding character.
//   A stalled output holds its item; the parser stops popping the queue,
//   and in_tready drops once both queue entries are filled.
//   Reset empties the queue and output register and returns the parser
//   to idle, ignoring characters until a first-marked item.
`default_nettype none
module ascii_integer_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic [0:0]  in_tuser,   // [0] first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] value
  output logic [0:0]       out_tuser   // [0] error
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  aip_pkg::cls_t q_wdata;
  aip_pkg::cls_t q_rdata;

  aip_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  aip_queue #(
    .WIDTH (aip_pkg::CLS_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  aip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
